FILE: rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

	// sizing
	localparam int MAX_TOKEN_LEN = 255;
	localparam int POS_W = 16;
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// result queue sizing
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [3:0] {
		TK_NUMBER    = 4'd0,
		TK_IDENT     = 4'd1,
		TK_LET       = 4'd2,
		TK_PRINT     = 4'd3,
		TK_PLUS      = 4'd4,
		TK_MINUS     = 4'd5,
		TK_ASSIGN    = 4'd6,
		TK_SEMICOLON = 4'd7,
		TK_LPAREN    = 4'd8,
		TK_RPAREN    = 4'd9,
		TK_INVALID   = 4'd10
	} token_kind_t;

	typedef enum logic [1:0] {
		RUN_NONE = 2'd0,
		RUN_NUM  = 2'd1,
		RUN_ID   = 2'd2
	} run_class_t;

	typedef struct packed {
		token_kind_t token_kind;
		logic [15:0] first_line;
		logic [15:0] first_column;
		logic [7:0]  token_length;
		logic        last_of_run;
	} token_t;

	// tokens produced by one accepted beat, slot a first
	typedef struct packed {
		logic [1:0] count;
		token_t     tok_a;
		token_t     tok_b;
	} push_t;

	function automatic logic [15:0] clamp_pos(input logic [POS_W-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		if (w > 33'h0_0000_FFFF) return 16'hFFFF;
		return w[15:0];
	endfunction

	function automatic logic [7:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		if (w > 33'h0_0000_00FF) return 8'hFF;
		return w[7:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/stt_in_if.sv
`default_nettype none

interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

FILE: rtl/stt_tok_if.sv
`default_nettype none

interface stt_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] first_line;
	logic [15:0] first_column;
	logic [7:0]  token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output first_line, output first_column,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input first_line, input first_column,
		input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/source_text_tokenizer_top.sv
// source text tokenizer
// in_ch carries one source byte per beat (char_byte), or an end marker
// (end_of_input set) that flushes a pending number or word run.
// out_ch carries token beats: kind, start line and column, length, and
// last_of_run, set on the final token that one input beat produced.
// a byte gives zero, one or two tokens; a byte that closes a run and is
// itself a symbol gives the run token first, then its own.
// a token is written into the result queue when the beat that closes
// it is accepted, and is offered on out_ch once it reaches the head.
// throughput: one input beat per cycle while the receiver keeps up; the
// lexer state updates once per accepted byte. a beat that gives two tokens
// hands them out one at a time, drained through a four-entry result queue.
// in_ch.ready drops while the queue holds more than two tokens, so a
// stalled receiver holds off input without losing or repeating tokens.
// reset: position 1:1, no pending run, result queue empty.
`default_nettype none

module source_text_tokenizer_top (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_in_if.sink    in_ch,
	stt_tok_if.source out_ch
);
	import stt_pkg::*;

	logic  space_ok;
	logic  accept;
	push_t push;

	assign in_ch.ready = space_ok;
	assign accept      = in_ch.valid && space_ok;

	// byte classification and run tracking
	stt_lexer_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_byte    (in_ch.char_byte),
		.end_of_input (in_ch.end_of_input),
		.push         (push)
	);

	// result queue
	stt_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire

FILE: rtl/stt_lexer_core.sv
`default_nettype none

module stt_lexer_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [7:0]     char_byte,
	input  wire logic           end_of_input,
	output stt_pkg::push_t      push
);
	import stt_pkg::*;

	logic [POS_W-1:0] cur_line_q, cur_column_q;
	run_class_t       pend_class_q;
	logic [POS_W-1:0] pend_line_q, pend_column_q;
	logic [LEN_W-1:0] pend_len_q;
	logic             let_q, print_q;

	logic [POS_W-1:0] cur_line_d, cur_column_d;
	run_class_t       pend_class_d;
	logic [POS_W-1:0] pend_line_d, pend_column_d;
	logic [LEN_W-1:0] pend_len_d;
	logic             let_d, print_d;

	logic        is_digit, is_alpha, is_space;
	run_class_t  byte_class;
	token_kind_t run_kind, punct_kind;
	logic        have_run, have_punct;
	token_t      run_tok, punct_tok;

	function automatic logic [7:0] let_char(input logic [LEN_W-1:0] i);
		if (32'(i) == 0) return "l";
		if (32'(i) == 1) return "e";
		return "t";
	endfunction

	function automatic logic [7:0] print_char(input logic [LEN_W-1:0] i);
		if (32'(i) == 0) return "p";
		if (32'(i) == 1) return "r";
		if (32'(i) == 2) return "i";
		if (32'(i) == 3) return "n";
		return "t";
	endfunction

	// byte classes
	always_comb begin
		is_digit = (char_byte >= "0") && (char_byte <= "9");
		is_alpha = ((char_byte >= "A") && (char_byte <= "Z")) ||
			((char_byte >= "a") && (char_byte <= "z"));
		is_space = (char_byte == " ") || ((char_byte >= 8'd9) && (char_byte <= 8'd13));
		byte_class = is_digit ? RUN_NUM : RUN_ID;
		unique case (char_byte)
			"+":     punct_kind = TK_PLUS;
			"-":     punct_kind = TK_MINUS;
			"=":     punct_kind = TK_ASSIGN;
			";":     punct_kind = TK_SEMICOLON;
			"(":     punct_kind = TK_LPAREN;
			")":     punct_kind = TK_RPAREN;
			default: punct_kind = TK_INVALID;
		endcase
	end

	// kind of the pending run when it closes
	always_comb begin
		if (pend_class_q == RUN_NUM) begin
			run_kind = TK_NUMBER;
		end else if (let_q && (32'(pend_len_q) == 3)) begin
			run_kind = TK_LET;
		end else if (print_q && (32'(pend_len_q) == 5)) begin
			run_kind = TK_PRINT;
		end else begin
			run_kind = TK_IDENT;
		end
	end

	// next state and tokens for this beat
	always_comb begin
		cur_line_d    = cur_line_q;
		cur_column_d  = cur_column_q;
		pend_class_d  = pend_class_q;
		pend_line_d   = pend_line_q;
		pend_column_d = pend_column_q;
		pend_len_d    = pend_len_q;
		let_d         = let_q;
		print_d       = print_q;
		have_run      = 1'b0;
		have_punct    = 1'b0;

		if (end_of_input) begin
			have_run = (pend_class_q != RUN_NONE);
		end else begin
			// position of the next byte
			if (char_byte == 8'h0A) begin
				if (cur_line_q < POS_MAX) cur_line_d = cur_line_q + 1'b1;
				cur_column_d = {{(POS_W-1){1'b0}}, 1'b1};
			end else if (cur_column_q < POS_MAX) begin
				cur_column_d = cur_column_q + 1'b1;
			end

			if (is_digit || is_alpha) begin
				if (pend_class_q != byte_class) begin
					have_run      = (pend_class_q != RUN_NONE);
					pend_class_d  = byte_class;
					pend_line_d   = cur_line_q;
					pend_column_d = cur_column_q;
					pend_len_d    = {{(LEN_W-1){1'b0}}, 1'b1};
					let_d         = (byte_class == RUN_ID) && (char_byte == "l");
					print_d       = (byte_class == RUN_ID) && (char_byte == "p");
				end else begin
					let_d   = let_q && (32'(pend_len_q) < 3) && (let_char(pend_len_q) == char_byte);
					print_d = print_q && (32'(pend_len_q) < 5) &&
						(print_char(pend_len_q) == char_byte);
					if (32'(pend_len_q) < MAX_TOKEN_LEN) pend_len_d = pend_len_q + 1'b1;
				end
			end else begin
				have_run   = (pend_class_q != RUN_NONE);
				have_punct = !is_space;
			end
		end

		// a closed run leaves no pending state behind
		if (have_run && !(is_digit || is_alpha) || have_run && end_of_input) begin
			pend_class_d = RUN_NONE;
			let_d        = 1'b0;
			print_d      = 1'b0;
		end

		run_tok.token_kind   = run_kind;
		run_tok.first_line   = clamp_pos(pend_line_q);
		run_tok.first_column = clamp_pos(pend_column_q);
		run_tok.token_length = clamp_len(pend_len_q);
		run_tok.last_of_run  = !have_punct;

		punct_tok.token_kind   = punct_kind;
		punct_tok.first_line   = clamp_pos(cur_line_q);
		punct_tok.first_column = clamp_pos(cur_column_q);
		punct_tok.token_length = 8'd1;
		punct_tok.last_of_run  = 1'b1;

		push.tok_a = have_run ? run_tok : punct_tok;
		push.tok_b = punct_tok;
		push.count = accept ? (2'(have_run) + 2'(have_punct)) : 2'd0;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q    <= {{(POS_W-1){1'b0}}, 1'b1};
			cur_column_q  <= {{(POS_W-1){1'b0}}, 1'b1};
			pend_class_q  <= RUN_NONE;
			pend_line_q   <= '0;
			pend_column_q <= '0;
			pend_len_q    <= '0;
			let_q         <= 1'b0;
			print_q       <= 1'b0;
		end else if (accept) begin
			cur_line_q    <= cur_line_d;
			cur_column_q  <= cur_column_d;
			pend_class_q  <= pend_class_d;
			pend_line_q   <= pend_line_d;
			pend_column_q <= pend_column_d;
			pend_len_q    <= pend_len_d;
			let_q         <= let_d;
			print_q       <= print_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/stt_out_queue.sv
`default_nettype none

module stt_out_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stt_pkg::push_t push,
	output logic            space_ok,
	stt_tok_if.source       out_ch
);
	import stt_pkg::*;

	token_t             entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               pop;
	logic [Q_PTR_W-1:0] wr_next;
	token_t             head;

	// room for two tokens regardless of this cycle's pop
	assign space_ok = (32'(count_q) <= Q_DEPTH - 2);
	assign pop      = out_ch.valid && out_ch.ready;
	assign wr_next  = wr_ptr_q + 1'b1;

	// head beat
	assign head                = entry_q[rd_ptr_q];
	assign out_ch.valid        = (count_q != '0);
	assign out_ch.token_kind   = head.token_kind;
	assign out_ch.first_line   = head.first_line;
	assign out_ch.first_column = head.first_column;
	assign out_ch.token_length = head.token_length;
	assign out_ch.last_of_run  = head.last_of_run;

	// token storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) entry_q[wr_ptr_q] <= push.tok_a;
		if (push.count == 2'd2) entry_q[wr_next] <= push.tok_b;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire
